[sv/binary_max_heap_queue_defines.svh]
// Assertion helpers for the checker file.
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMHQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BMHQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/bmhq_pkg.sv]
`default_nettype none
package bmhq_pkg;

	localparam int KEY_W  = 32;
	localparam int SLOT_W = 9;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0]  popped_key;
		logic [SLOT_W-1:0] settled_slot;
		status_t           status;
		logic [SLOT_W-1:0] entry_count;
	} rsp_t;

	// microprogram step addresses
	typedef enum logic [3:0] {
		S_DISPATCH,
		S_U_CHK,
		S_U_INIT,
		S_U_RD,
		S_U_CMP,
		S_FIN,
		S_P_ROOT,
		S_P_LAST,
		S_P_TAKE,
		S_D_LEFT,
		S_D_RIGHT,
		S_D_CMP,
		S_D_EXIT,
		S_ERR
	} step_t;

	typedef enum logic [2:0] {
		ADR_NONE,
		ADR_PARENT,
		ADR_LEFT,
		ADR_RIGHT,
		ADR_ROOT,
		ADR_LAST
	} adr_sel_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_PUSH_INIT,
		ACT_UP_CMP,
		ACT_CAP_ROOT,
		ACT_CAP_LAST,
		ACT_CAP_LEFT,
		ACT_DOWN_CMP,
		ACT_FINISH,
		ACT_ERROR
	} act_t;

	typedef enum logic [2:0] {
		JC_NEVER,
		JC_ALWAYS,
		JC_IS_POP,
		JC_FULL,
		JC_EMPTY,
		JC_AT_ROOT,
		JC_NO_CHILD,
		JC_MOVED
	} jcond_t;

	typedef struct packed {
		adr_sel_t adr;
		act_t     act;
		jcond_t   jc;
		step_t    target;
		logic     last;
	} uword_t;

	typedef struct packed {
		logic is_pop;
		logic full;
		logic empty;
		logic at_root;
		logic no_child;
		logic moved;
	} dp_flags_t;

endpackage
`default_nettype wire

[sv/bmhq_ram.sv]
`default_nettype none
module bmhq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[sv/bmhq_seq.sv]
`default_nettype none
module bmhq_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bmhq_pkg::dp_flags_t flags,
	output bmhq_pkg::uword_t   uw,
	output logic               busy,
	output logic               done
);
	import bmhq_pkg::*;

	// control store: {address select, action, jump condition, target, last}
	function automatic uword_t ucode(step_t s);
		uword_t w;
		w = '{ADR_NONE, ACT_NONE, JC_NEVER, S_DISPATCH, 1'b0};
		unique case (s)
			S_DISPATCH: w = '{ADR_NONE,   ACT_NONE,      JC_IS_POP,   S_P_ROOT,   1'b0};
			S_U_CHK:    w = '{ADR_NONE,   ACT_NONE,      JC_FULL,     S_ERR,      1'b0};
			S_U_INIT:   w = '{ADR_NONE,   ACT_PUSH_INIT, JC_NEVER,    S_DISPATCH, 1'b0};
			S_U_RD:     w = '{ADR_PARENT, ACT_NONE,      JC_AT_ROOT,  S_FIN,      1'b0};
			S_U_CMP:    w = '{ADR_NONE,   ACT_UP_CMP,    JC_MOVED,    S_U_RD,     1'b0};
			S_FIN:      w = '{ADR_NONE,   ACT_FINISH,    JC_NEVER,    S_DISPATCH, 1'b1};
			S_P_ROOT:   w = '{ADR_ROOT,   ACT_NONE,      JC_EMPTY,    S_ERR,      1'b0};
			S_P_LAST:   w = '{ADR_LAST,   ACT_CAP_ROOT,  JC_NEVER,    S_DISPATCH, 1'b0};
			S_P_TAKE:   w = '{ADR_NONE,   ACT_CAP_LAST,  JC_NEVER,    S_DISPATCH, 1'b0};
			S_D_LEFT:   w = '{ADR_LEFT,   ACT_NONE,      JC_NO_CHILD, S_FIN,      1'b0};
			S_D_RIGHT:  w = '{ADR_RIGHT,  ACT_CAP_LEFT,  JC_NEVER,    S_DISPATCH, 1'b0};
			S_D_CMP:    w = '{ADR_NONE,   ACT_DOWN_CMP,  JC_MOVED,    S_D_LEFT,   1'b0};
			S_D_EXIT:   w = '{ADR_NONE,   ACT_NONE,      JC_ALWAYS,   S_FIN,      1'b0};
			S_ERR:      w = '{ADR_NONE,   ACT_ERROR,     JC_NEVER,    S_DISPATCH, 1'b1};
			default:    w = '{ADR_NONE,   ACT_NONE,      JC_NEVER,    S_DISPATCH, 1'b1};
		endcase
		return w;
	endfunction

	step_t upc_q, upc_d;
	logic  run_q, run_d;
	logic  done_q;
	logic  take;

	// outputs
	always_comb begin
		uw   = ucode(upc_q);
		busy = run_q;
		done = done_q;
	end

	always_comb begin
		unique case (uw.jc)
			JC_NEVER:    take = 1'b0;
			JC_ALWAYS:   take = 1'b1;
			JC_IS_POP:   take = flags.is_pop;
			JC_FULL:     take = flags.full;
			JC_EMPTY:    take = flags.empty;
			JC_AT_ROOT:  take = flags.at_root;
			JC_NO_CHILD: take = flags.no_child;
			JC_MOVED:    take = flags.moved;
			default:     take = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		if (!run_q) begin
			run_d = start;
			upc_d = S_DISPATCH;
		end else if (uw.last) begin
			run_d = 1'b0;
			upc_d = S_DISPATCH;
		end else begin
			run_d = 1'b1;
			upc_d = take ? uw.target : step_t'(upc_q + 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			upc_q  <= S_DISPATCH;
			done_q <= 1'b0;
		end else begin
			run_q  <= run_d;
			upc_q  <= upc_d;
			done_q <= run_q && uw.last;
		end
	end

endmodule
`default_nettype wire

[sv/bmhq_dp.sv]
`default_nettype none
module bmhq_dp #(
	parameter int CAPACITY = 256,
	parameter int KEY_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  bmhq_pkg::req_t      req,
	input  bmhq_pkg::uword_t    uw,
	output bmhq_pkg::dp_flags_t flags,
	output bmhq_pkg::rsp_t      rsp
);
	import bmhq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	cmd_t                cmd_q;
	logic [KEY_BITS-1:0] x_q;      // key being sifted (the hole's occupant)
	logic [KEY_BITS-1:0] left_q;
	logic [KEY_BITS-1:0] pop_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       k_q;
	rsp_t                rsp_q;

	logic [CW:0]         lchild, rchild, cnt_x, rd_slot;
	logic [CW-1:0]       parent, down_slot;
	logic [KEY_BITS-1:0] rd_data, down_val, wdata;
	logic [AW-1:0]       raddr, waddr;
	logic                re, we, pick_r, moved, is_pop;

	assign lchild = {k_q, 1'b0};
	assign rchild = {k_q, 1'b1};
	assign parent = k_q >> 1;
	assign cnt_x  = {1'b0, cnt_q};
	assign is_pop = (cmd_q == CMD_POP);

	always_comb begin
		unique case (uw.adr)
			ADR_PARENT: rd_slot = {1'b0, parent};
			ADR_LEFT:   rd_slot = lchild;
			ADR_RIGHT:  rd_slot = rchild;
			ADR_ROOT:   rd_slot = (CW + 1)'(1);
			ADR_LAST:   rd_slot = cnt_x;
			default:    rd_slot = '0;
		endcase
	end

	assign re    = (uw.adr != ADR_NONE);
	assign raddr = AW'(rd_slot - 1'b1);

	// larger child, left wins a tie
	assign pick_r    = (rchild <= cnt_x) && (rd_data > left_q);
	assign down_val  = pick_r ? rd_data : left_q;
	assign down_slot = pick_r ? rchild[CW-1:0] : lchild[CW-1:0];

	always_comb begin
		moved = 1'b0;
		we    = 1'b0;
		wdata = x_q;
		unique case (uw.act)
			ACT_UP_CMP: begin
				moved = (x_q > rd_data);
				we    = moved;
				wdata = rd_data;
			end
			ACT_DOWN_CMP: begin
				moved = (down_val > x_q);
				we    = moved;
				wdata = down_val;
			end
			ACT_FINISH: begin
				we    = 1'b1;
				wdata = x_q;
			end
			default: begin
				moved = 1'b0;
			end
		endcase
	end

	assign waddr = AW'(k_q - 1'b1);

	assign flags = '{
		is_pop:   is_pop,
		full:     (cnt_q == CW'(CAPACITY)),
		empty:    (cnt_q == '0),
		at_root:  (k_q == CW'(1)),
		no_child: (lchild > cnt_x),
		moved:    moved
	};

	assign rsp = rsp_q;

	bmhq_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			priority case (uw.act)
				ACT_PUSH_INIT: cnt_q <= cnt_q + 1'b1;
				ACT_CAP_LAST:  cnt_q <= cnt_q - 1'b1;
				default:       cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= req.cmd;
			x_q   <= KEY_BITS'(req.key);
		end else begin
			unique case (uw.act)
				ACT_PUSH_INIT: k_q <= cnt_q + 1'b1;
				ACT_UP_CMP: begin
					if (moved) begin
						k_q <= parent;
					end
				end
				ACT_CAP_ROOT: pop_q  <= rd_data;
				ACT_CAP_LAST: begin
					x_q <= rd_data;
					k_q <= CW'(1);
				end
				ACT_CAP_LEFT: left_q <= rd_data;
				ACT_DOWN_CMP: begin
					if (moved) begin
						k_q <= down_slot;
					end
				end
				ACT_FINISH: begin
					rsp_q.popped_key   <= is_pop ? KEY_W'(pop_q) : '0;
					rsp_q.settled_slot <= is_pop ? '0 : SLOT_W'(k_q);
					rsp_q.status       <= ST_OK;
					rsp_q.entry_count  <= SLOT_W'(cnt_q);
				end
				ACT_ERROR: begin
					rsp_q.popped_key   <= '0;
					rsp_q.settled_slot <= '0;
					rsp_q.status       <= is_pop ? ST_EMPTY : ST_FULL;
					rsp_q.entry_count  <= SLOT_W'(cnt_q);
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[sv/binary_max_heap_queue.sv]
// Push: check full, open the hole at the tail, then per level climbed a parent read and
//   a compare/write, and a final write of the key. Pop: check empty, read root and tail,
//   then per level descended a left read, a right read and a compare/write, and a final
//   write. An error request ends after its check.
// One request in flight; the next is taken in the done cycle.
// done strobes one cycle and cannot be stalled; arst_n clears sequencer and entry count only.
`default_nettype none
module binary_max_heap_queue #(
	parameter int CAPACITY = 256,
	parameter int KEY_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bmhq_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output bmhq_pkg::rsp_t rsp
);
	import bmhq_pkg::*;

	// Control words flow from the sequencer; condition flags flow back.
	uword_t    uw;
	dp_flags_t flags;
	logic      load;

	// A request is taken only while the sequencer sits at its dispatch step.
	assign load = start && !busy;

	// Microcoded sequencer: step counter plus control store with conditional jumps.
	// Push program: check full, open a hole at the tail, then move parents down
	// into the hole while the new key is strictly larger.
	// Pop program: check empty, fetch root and tail, then move the larger child
	// (left on a tie) up into the hole while it is strictly larger than the tail key.
	bmhq_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.flags (flags),
		.uw    (uw),
		.busy  (busy),
		.done  (done)
	);

	// Datapath: key store RAM (registered read), hole index, count, result register.
	bmhq_dp #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (load),
		.req   (req),
		.uw    (uw),
		.flags (flags),
		.rsp   (rsp)
	);

endmodule
`default_nettype wire

[sv/bmhq_checker.sv]
`default_nettype none
`include "binary_max_heap_queue_defines.svh"
module bmhq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input bmhq_pkg::rsp_t rsp
);
	import bmhq_pkg::*;

	`BMHQ_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "request not taken")
	`BMHQ_ASSERT_IMP(a_done_end, clk, arst_n, done, $fell(busy), "done without end of work")
	`BMHQ_ASSERT_IMP(a_err_zero, clk, arst_n, done && (rsp.status != ST_OK), (rsp.popped_key == '0) && (rsp.settled_slot == '0), "error result carries data")
	`BMHQ_ASSERT_IMP(a_empty_cnt, clk, arst_n, done && (rsp.status == ST_EMPTY), rsp.entry_count == '0, "empty error with entries held")

endmodule

bind binary_max_heap_queue bmhq_checker u_bmhq_checker (.*);
`default_nettype wire
